// ----- rtl/pmr_pkg.sv -----
// Shared types and constants for the polyline mask rasterizer.
`default_nettype none

package pmr_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam int COORD_W   = 16;  // signed vertex coordinates
  localparam int DIM_W     = 7;   // mask size registers
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;   // widest register
  localparam int CMD_W     = 2;
  localparam int PIX_W     = 8;
  localparam int ERR_W     = 20;  // Bresenham error term, signed

  localparam logic [PIX_W-1:0] PIX_SET   = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_CLEAR = 8'h00;

  typedef enum logic [CMD_W-1:0] {
    CMD_VERTEX = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASK_WIDTH  = 2'd0,
    REG_MASK_HEIGHT = 2'd1,
    REG_CLOSED_PATH = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_INIT,   // clearing pass after reset
    S_IDLE,
    S_LINE,   // walking the segment to the new vertex
    S_CLOSE,  // walking the closing segment
    S_READ,   // read data ready, waiting for the output slot
    S_DONE,   // done beat waiting for the output slot
    S_CLEAR   // clearing pass on a clear command
  } state_t;

  typedef struct packed {
    logic accept_vertex;
    logic accept_read;
    logic start_clear;
    logic clear_step;
    logic walk;
    logic start_close;
  } dp_cmd_t;

  typedef struct packed {
    logic seg_done;   // walker sits on the segment end
    logic clr_done;   // clear counter on the last entry
    logic single;     // current segment came from a first vertex
    logic last;       // current vertex ends the polyline
    logic rd_hit;     // read pixel is inside and set
  } dp_stat_t;

  typedef struct packed {
    logic load;
    logic is_read;
  } out_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/pmr_ctrl.sv -----
// Control state machine: sequences vertices, reads, clears and result beats.
`default_nettype none

module pmr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire pmr_pkg::cmd_t     in_cmd,
  input  wire logic              closed_path,
  input  wire logic              out_free,
  input  wire pmr_pkg::dp_stat_t stat,
  output logic                   in_tready,
  output pmr_pkg::dp_cmd_t       dp_cmd,
  output pmr_pkg::out_ctl_t      out_ctl
);
  import pmr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_CLEAR: begin
        if (stat.clr_done) state_nxt = S_DONE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          case (in_cmd)
            CMD_VERTEX: state_nxt = S_LINE;
            CMD_READ:   state_nxt = S_READ;
            CMD_CLEAR:  state_nxt = S_CLEAR;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_LINE: begin
        if (stat.seg_done) begin
          if (!stat.last) begin
            state_nxt = S_IDLE;
          end else if (closed_path && !stat.single) begin
            state_nxt = S_CLOSE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CLOSE: begin
        if (stat.seg_done) state_nxt = S_DONE;
      end
      S_READ, S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    dp_cmd    = '0;
    out_ctl   = '0;
    case (state_r)
      S_INIT, S_CLEAR: begin
        dp_cmd.clear_step = 1'b1;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_cmd)
            CMD_VERTEX: dp_cmd.accept_vertex = 1'b1;
            CMD_READ:   dp_cmd.accept_read   = 1'b1;
            CMD_CLEAR:  dp_cmd.start_clear   = 1'b1;
            default:    ;
          endcase
        end
      end
      S_LINE: begin
        dp_cmd.walk = 1'b1;
        if (stat.seg_done && stat.last && closed_path && !stat.single) begin
          dp_cmd.start_close = 1'b1;
        end
      end
      S_CLOSE: begin
        dp_cmd.walk = 1'b1;
      end
      S_READ: begin
        out_ctl.load    = out_free;
        out_ctl.is_read = 1'b1;
      end
      S_DONE: begin
        out_ctl.load = out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/pmr_datapath.sv -----
// Datapath: vertex registers, Bresenham walker, clear counter and mask memory.
`default_nettype none

module pmr_datapath #(
  parameter int MAX_WIDTH  = pmr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pmr_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic signed [pmr_pkg::COORD_W-1:0]  in_x,
  input  wire logic signed [pmr_pkg::COORD_W-1:0]  in_y,
  input  wire logic                                in_last,
  input  wire logic        [pmr_pkg::DIM_W-1:0]    mask_width,
  input  wire logic        [pmr_pkg::DIM_W-1:0]    mask_height,
  input  wire pmr_pkg::dp_cmd_t                    cmd,
  output pmr_pkg::dp_stat_t                        stat
);
  import pmr_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int UW    = COORD_W + 1;

  function automatic logic inside_f(input logic signed [COORD_W-1:0] px,
                                    input logic signed [COORD_W-1:0] py,
                                    input logic [UW-1:0] uw,
                                    input logic [UW-1:0] uh);
    return !px[COORD_W-1] && !py[COORD_W-1] &&
           ({1'b0, px} < uw) && ({1'b0, py} < uh);
  endfunction

  function automatic logic [AW-1:0] addr_f(input logic signed [COORD_W-1:0] px,
                                           input logic signed [COORD_W-1:0] py);
    logic [31:0] a;
    a = 32'($unsigned(py)) * 32'(MAX_WIDTH) + 32'($unsigned(px));
    return a[AW-1:0];
  endfunction

  logic [UW-1:0] used_w, used_h;
  assign used_w = (UW'(mask_width) > UW'(MAX_WIDTH)) ? UW'(MAX_WIDTH) : UW'(mask_width);
  assign used_h = (UW'(mask_height) > UW'(MAX_HEIGHT)) ? UW'(MAX_HEIGHT)
                                                        : UW'(mask_height);

  // vertex bookkeeping
  logic                      awaiting_first_r;
  logic                      single_r, last_r;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r, start_x_r, start_y_r;

  // walker
  logic signed [COORD_W-1:0] cur_x_r, cur_y_r, end_x_r, end_y_r;
  logic        [COORD_W:0]   adx_r, ady_r;
  logic                      x_neg_r, y_neg_r;
  logic signed [ERR_W-1:0]   err_r;

  // segment setup
  logic signed [COORD_W-1:0] x0, y0, x1, y1;
  logic signed [COORD_W:0]   dx, dy;
  logic        [COORD_W:0]   adx_s, ady_s;

  always_comb begin
    if (cmd.start_close) begin
      x0 = end_x_r;
      y0 = end_y_r;
      x1 = start_x_r;
      y1 = start_y_r;
    end else begin
      x0 = awaiting_first_r ? in_x : prev_x_r;
      y0 = awaiting_first_r ? in_y : prev_y_r;
      x1 = in_x;
      y1 = in_y;
    end
    dx    = (COORD_W+1)'(x1) - (COORD_W+1)'(x0);
    dy    = (COORD_W+1)'(y1) - (COORD_W+1)'(y0);
    adx_s = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
    ady_s = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
  end

  // one Bresenham step
  logic signed [ERR_W:0]     e2, lim_x, lim_y;
  logic                      mv_x, mv_y, seg_done;
  logic signed [ERR_W-1:0]   err_step;

  assign seg_done = (cur_x_r == end_x_r) && (cur_y_r == end_y_r);
  assign e2       = {err_r, 1'b0};
  assign lim_x    = -$signed((ERR_W+1)'(ady_r));
  assign lim_y    = $signed((ERR_W+1)'(adx_r));
  assign mv_x     = e2 >= lim_x;
  assign mv_y     = e2 <= lim_y;
  assign err_step = err_r - (mv_x ? ERR_W'(ady_r) : ERR_W'(0))
                          + (mv_y ? ERR_W'(adx_r) : ERR_W'(0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_first_r <= 1'b1;
    end else if (cmd.accept_vertex) begin
      awaiting_first_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_vertex) begin
      prev_x_r <= in_x;
      prev_y_r <= in_y;
      single_r <= awaiting_first_r;
      last_r   <= in_last;
      if (awaiting_first_r) begin
        start_x_r <= in_x;
        start_y_r <= in_y;
      end
    end
    if (cmd.accept_vertex || cmd.start_close) begin
      cur_x_r <= x0;
      cur_y_r <= y0;
      end_x_r <= x1;
      end_y_r <= y1;
      adx_r   <= adx_s;
      ady_r   <= ady_s;
      x_neg_r <= !(x0 < x1);
      y_neg_r <= !(y0 < y1);
      err_r   <= ERR_W'(adx_s) - ERR_W'(ady_s);
    end else if (cmd.walk && !seg_done) begin
      err_r <= err_step;
      if (mv_x) cur_x_r <= x_neg_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
      if (mv_y) cur_y_r <= y_neg_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
    end
  end

  // clear counter
  logic [AW-1:0] clr_cnt_r;
  logic          clr_done;
  assign clr_done = clr_cnt_r == AW'(DEPTH - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.start_clear) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // mask memory: one write port, one registered read port
  logic          mem_r [DEPTH];
  logic          mem_we, mem_wd;
  logic [AW-1:0] mem_wa, rd_addr;
  logic          rd_data_r, rd_inside_r;

  assign mem_we  = cmd.clear_step ||
                   (cmd.walk && inside_f(cur_x_r, cur_y_r, used_w, used_h));
  assign mem_wa  = cmd.clear_step ? clr_cnt_r : addr_f(cur_x_r, cur_y_r);
  assign mem_wd  = !cmd.clear_step;
  assign rd_addr = addr_f(in_x, in_y);

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_wa] <= mem_wd;
    if (cmd.accept_read) begin
      rd_data_r   <= mem_r[rd_addr];
      rd_inside_r <= inside_f(in_x, in_y, used_w, used_h);
    end
  end

  always_comb begin
    stat.seg_done = seg_done;
    stat.clr_done = clr_done;
    stat.single   = single_r;
    stat.last     = last_r;
    stat.rd_hit   = rd_inside_r && rd_data_r;
  end

endmodule

`default_nettype wire

// ----- rtl/polyline_mask_rasterizer.sv -----
// Top level of the polyline mask rasterizer: config registers, output register.
`default_nettype none

// Draws polylines into a one-bit mask of MAX_WIDTH x MAX_HEIGHT pixels with
// Bresenham segments, one pixel per clock. Each input beat is a command in
// in_tuser: a vertex, a read of one pixel, or a clear. A vertex beat is taken,
// then its segment from the previous vertex is walked pixel by pixel (both
// ends included); the first vertex of a polyline walks a one-pixel segment.
// On the last vertex of a closed path, a closing segment back to the first
// vertex is walked the same way; a last vertex then loads its done beat. A
// read is a registered memory read; a clear sweeps the mask one entry a cycle.
// A read, clear or done beat that finds the output register still full waits
// there until it frees. After reset the same sweep over all MAX_WIDTH*MAX_HEIGHT
// entries (4096 by default) runs with in_tready low. Config writes are taken at
// any time but should only be issued while idle. Results sit in an output
// register, so the next command is taken while a result beat waits for
// out_tready. Each vertex is a single-slot sequential job: the walk is the
// pacing loop.
module polyline_mask_rasterizer #(
  parameter int MAX_WIDTH  = pmr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pmr_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [2*pmr_pkg::COORD_W-1:0]     in_tdata,   // x_coord, y_coord
  input  wire logic [pmr_pkg::CMD_W-1:0]         in_tuser,   // command
  input  wire logic                              in_tlast,   // last_vertex
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [pmr_pkg::PIX_W-1:0]              out_tdata,  // pixel_value
  output logic                                   out_tuser,  // path_done
  // config write port
  input  wire logic                              cfg_wr_en,
  input  wire logic [pmr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pmr_pkg::CFG_W-1:0]         cfg_wdata
);
  import pmr_pkg::*;

  // config registers
  logic [DIM_W-1:0] mask_width_r, mask_height_r;
  logic             closed_path_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_width_r  <= DIM_W'(64);
      mask_height_r <= DIM_W'(64);
      closed_path_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_MASK_WIDTH:  mask_width_r  <= cfg_wdata[DIM_W-1:0];
        REG_MASK_HEIGHT: mask_height_r <= cfg_wdata[DIM_W-1:0];
        REG_CLOSED_PATH: closed_path_r <= cfg_wdata[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // beat fields
  logic signed [COORD_W-1:0] in_x, in_y;
  assign in_x = $signed(in_tdata[COORD_W-1:0]);
  assign in_y = $signed(in_tdata[2*COORD_W-1:COORD_W]);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  out_ctl_t out_ctl;

  // output register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_done_r;
  logic             out_free;

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ctl.load) begin
      out_pix_r  <= (out_ctl.is_read && dp_stat.rd_hit) ? PIX_SET : PIX_CLEAR;
      out_done_r <= !out_ctl.is_read;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tuser  = out_done_r;

  pmr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_cmd      (cmd_t'(in_tuser)),
    .closed_path (closed_path_r),
    .out_free    (out_free),
    .stat        (dp_stat),
    .in_tready   (in_tready),
    .dp_cmd      (dp_cmd),
    .out_ctl     (out_ctl)
  );

  pmr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_x        (in_x),
    .in_y        (in_y),
    .in_last     (in_tlast),
    .mask_width  (mask_width_r),
    .mask_height (mask_height_r),
    .cmd         (dp_cmd),
    .stat        (dp_stat)
  );

  // the clearing pass keeps the input closed right after reset
  a_init_closed: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input open during clearing pass");

  // a read beat carries 255 or 0 only
  a_pix_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> (out_tdata == PIX_SET || out_tdata == PIX_CLEAR))
    else $error("read beat with bad pixel code");

  // done beats carry a zero pixel
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == PIX_CLEAR)
    else $error("done beat with nonzero pixel");

  // a new result is only loaded when the slot frees
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_ctl.load |-> out_free)
    else $error("result register overwritten");

endmodule

`default_nettype wire
